### design/ism_pkg.sv
// ----------------------------------------------------------------------------
// Integer stack machine package
// Command and response transfer types, operation codes and status codes.
// ----------------------------------------------------------------------------
package ism_pkg;

	localparam int DATA_W = 32;

	localparam logic [2:0] KIND_PUSH = 3'd0;
	localparam logic [2:0] KIND_PALL = 3'd1;
	localparam logic [2:0] KIND_PINT = 3'd2;
	localparam logic [2:0] KIND_POP  = 3'd3;
	localparam logic [2:0] KIND_SWAP = 3'd4;
	localparam logic [2:0] KIND_ADD  = 3'd5;
	localparam logic [2:0] KIND_NOP  = 3'd6;

	localparam logic [2:0] STATUS_OK         = 3'd0;
	localparam logic [2:0] STATUS_PINT_EMPTY = 3'd1;
	localparam logic [2:0] STATUS_POP_EMPTY  = 3'd2;
	localparam logic [2:0] STATUS_SWAP_SHORT = 3'd3;
	localparam logic [2:0] STATUS_ADD_SHORT  = 3'd4;
	localparam logic [2:0] STATUS_PUSH_FULL  = 3'd5;

	typedef struct packed {
		logic [2:0]               kind;
		logic signed [DATA_W-1:0] push_value;
	} cmd_t;

	typedef struct packed {
		logic [2:0]               status;
		logic                     has_value;
		logic signed [DATA_W-1:0] elem_value;
		logic                     last;
	} rsp_t;

endpackage

### design/ism_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, with the read data registered.
// ----------------------------------------------------------------------------
module ism_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### design/integer_stack_machine.sv
// ----------------------------------------------------------------------------
// Integer stack machine
// Bounded stack of signed 32-bit integers driven by one opcode per command.
// ----------------------------------------------------------------------------
// Commands arrive on the cmd channel and responses leave on the rsp channel;
// both use valid and stall, and a transfer happens when valid is high and
// stall is low. Every command gives one response, except pall on a non-empty
// stack, which gives one response per element from top to bottom, with last
// set on the bottom element.
// The stack lives in a single RAM with a registered read; the
// element count is held in a register. Commands are executed one at a time.
// Push, pop, nop and every error finish in the cycle they are taken; pint
// reads the top; add reads top and second, then writes the sum; swap reads
// both, then writes each back in turn, as the RAM has one read and one write
// port. Pall reads the top, then emits one element per cycle. Each response
// is registered in the cycle after its work ends. While the receiver stalls,
// the output register holds its response, pall pauses, and no new command
// is taken. Reset empties the stack at once; the RAM contents are not cleared.
// ----------------------------------------------------------------------------
module integer_stack_machine #(
	parameter int STACK_DEPTH = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_stall,
	input  ism_pkg::cmd_t cmd,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output ism_pkg::rsp_t rsp
);

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_PINT   = 6'b000010,
		S_READ2  = 6'b000100,
		S_UPDATE = 6'b001000,
		S_SWAPWR = 6'b010000,
		S_PALL   = 6'b100000
	} state_t;

	state_t                      state_q, state_d;
	logic [CW-1:0]               count_q, count_d;
	logic [AW-1:0]               idx_q, idx_d;
	logic                        is_add_q;
	logic [ism_pkg::DATA_W-1:0]  top_q, second_q;
	logic                        rsp_valid_q;
	ism_pkg::rsp_t               rsp_q, emit_data;
	logic                        emit, out_free, accept;
	logic                        we;
	logic [AW-1:0]               waddr, raddr, top_addr, second_addr;
	logic [ism_pkg::DATA_W-1:0]  wdata, rdata;

	assign out_free    = !rsp_valid_q || !rsp_stall;
	assign accept      = cmd_valid && out_free && (state_q == S_IDLE);
	assign cmd_stall   = !(out_free && (state_q == S_IDLE));
	assign top_addr    = AW'(count_q - CW'(1));
	assign second_addr = AW'(count_q - CW'(2));
	assign rsp_valid   = rsp_valid_q;
	assign rsp         = rsp_q;

	always_comb begin
		state_d              = state_q;
		count_d              = count_q;
		idx_d                = idx_q;
		emit                 = 1'b0;
		emit_data.status     = ism_pkg::STATUS_OK;
		emit_data.has_value  = 1'b0;
		emit_data.elem_value = '0;
		emit_data.last       = 1'b1;
		we                   = 1'b0;
		waddr                = top_addr;
		wdata                = top_q;
		raddr                = top_addr;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (cmd.kind)
						ism_pkg::KIND_PUSH: begin
							emit = 1'b1;
							if (count_q == FULL) begin
								emit_data.status = ism_pkg::STATUS_PUSH_FULL;
							end else begin
								we      = 1'b1;
								waddr   = AW'(count_q);
								wdata   = cmd.push_value;
								count_d = count_q + CW'(1);
							end
						end
						ism_pkg::KIND_PALL: begin
							if (count_q == '0) begin
								emit = 1'b1;
							end else begin
								idx_d   = top_addr;
								state_d = S_PALL;
							end
						end
						ism_pkg::KIND_PINT: begin
							if (count_q == '0) begin
								emit             = 1'b1;
								emit_data.status = ism_pkg::STATUS_PINT_EMPTY;
							end else begin
								state_d = S_PINT;
							end
						end
						ism_pkg::KIND_POP: begin
							emit = 1'b1;
							if (count_q == '0) begin
								emit_data.status = ism_pkg::STATUS_POP_EMPTY;
							end else begin
								count_d = count_q - CW'(1);
							end
						end
						ism_pkg::KIND_SWAP, ism_pkg::KIND_ADD: begin
							if (count_q < CW'(2)) begin
								emit             = 1'b1;
								emit_data.status = (cmd.kind == ism_pkg::KIND_ADD) ?
									ism_pkg::STATUS_ADD_SHORT : ism_pkg::STATUS_SWAP_SHORT;
							end else begin
								state_d = S_READ2;
							end
						end
						default: begin
							emit = 1'b1;
						end
					endcase
				end
			end
			S_PINT: begin
				emit                 = 1'b1;
				emit_data.has_value  = 1'b1;
				emit_data.elem_value = rdata;
				state_d              = S_IDLE;
			end
			S_READ2: begin
				raddr   = second_addr;
				state_d = S_UPDATE;
			end
			S_UPDATE: begin
				we    = 1'b1;
				waddr = second_addr;
				if (is_add_q) begin
					wdata   = rdata + top_q;
					count_d = count_q - CW'(1);
					emit    = 1'b1;
					state_d = S_IDLE;
				end else begin
					wdata   = top_q;
					state_d = S_SWAPWR;
				end
			end
			S_SWAPWR: begin
				we      = 1'b1;
				waddr   = top_addr;
				wdata   = second_q;
				emit    = 1'b1;
				state_d = S_IDLE;
			end
			S_PALL: begin
				raddr = idx_q;
				if (out_free) begin
					emit                 = 1'b1;
					emit_data.has_value  = 1'b1;
					emit_data.elem_value = rdata;
					emit_data.last       = (idx_q == '0);
					if (idx_q == '0) begin
						state_d = S_IDLE;
					end else begin
						idx_d = idx_q - AW'(1);
						raddr = idx_q - AW'(1);
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (emit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_q <= idx_d;
		if (emit) begin
			rsp_q <= emit_data;
		end
		if (accept) begin
			is_add_q <= (cmd.kind == ism_pkg::KIND_ADD);
		end
		if (state_q == S_READ2) begin
			top_q <= rdata;
		end
		if (state_q == S_UPDATE) begin
			second_q <= rdata;
		end
	end

	ism_ram #(
		.WIDTH(ism_pkg::DATA_W),
		.DEPTH(STACK_DEPTH)
	) u_stack_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

endmodule

### design/ism_checker.sv
// ----------------------------------------------------------------------------
// Integer stack machine checker
// Port-level properties of the stack machine, bound to the top level.
// ----------------------------------------------------------------------------
module ism_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          cmd_valid,
	input logic          cmd_stall,
	input ism_pkg::cmd_t cmd,
	input logic          rsp_valid,
	input logic          rsp_stall,
	input ism_pkg::rsp_t rsp
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("Stalled response changed or vanished.");

	a_value_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.has_value |-> rsp.status == ism_pkg::STATUS_OK)
		else $error("Response carries a value with an error status.");

	a_error_shape: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != ism_pkg::STATUS_OK
		|-> rsp.last && !rsp.has_value && rsp.elem_value == '0)
		else $error("Error response is not a single empty transfer.");

	a_nop_next: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall && cmd.kind == ism_pkg::KIND_NOP
		|=> rsp_valid && rsp.last && rsp.status == ism_pkg::STATUS_OK)
		else $error("No response in the cycle after a nop transfer.");

	a_pall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.last |-> cmd_stall)
		else $error("Command taken while a pall is still in progress.");

endmodule

bind integer_stack_machine ism_checker u_ism_checker (.*);
